[rtl/sdts_pkg.sv]
// Package for the sorted-delay task scheduler.
// Holds the entry and cell command types and the action, status and op codes.
// Used by sdts_cell and sorted_delay_task_scheduler; depends on nothing.
`default_nettype none

package sdts_pkg;

    localparam int DELAY_W = 16;
    localparam int TAG_W   = 8;
    localparam int ID_W    = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // Action codes of an input request.
    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_TICK     = 2'd1;
    localparam logic [1:0] ACT_DISPATCH = 2'd2;

    // Status codes of a result.
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_DUE = 2'd2;

    // Operations broadcast to every cell of the chain.
    localparam logic [1:0] OP_HOLD    = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_SHIFT_L = 2'd3;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] period;
        logic [TAG_W-1:0]   tag;
        logic [ID_W-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        t_entry     ins;
    } t_cell_cmd;

endpackage

`default_nettype wire

[rtl/sdts_cell.sv]
// One slot of the sorted task chain: holds a single task entry.
// Inserts, decrements or shifts under a command shared by all slots.
// Depends on sdts_pkg.
`default_nettype none

module sdts_cell
    import sdts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_occ,
    input  wire logic      i_left_stay,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_stay
);

    t_entry r_entry;
    t_entry n_entry;

    // A held entry whose delay does not exceed the new one stays in place.
    assign o_stay  = i_occ && (r_entry.delay <= i_cmd.ins.delay);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            OP_HOLD: begin
                n_entry = r_entry;
            end
            OP_INSERT: begin
                if (o_stay) begin
                    n_entry = r_entry;
                end else if (i_left_stay) begin
                    n_entry = i_cmd.ins;
                end else begin
                    n_entry = i_left;
                end
            end
            OP_TICK: begin
                if (r_entry.delay != '0) begin
                    n_entry.delay = r_entry.delay - DELAY_W'(1);
                end
            end
            OP_SHIFT_L: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

[rtl/sorted_delay_task_scheduler.sv]
// Sorted-delay task scheduler: top level with the request handshake and control.
// Builds a chain of sdts_cell slots; depends on sdts_pkg and sdts_cell.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the action (add, tick,
//   dispatch), tdata carries the tag, start delay and repeat period of an add.
//   Every request gives exactly one result on the m_axis channel: tuser holds
//   the status and the run flag, tdata the run tag, assigned id and task count.
//   Tasks sit in a chain of MAX_TASKS slots kept sorted by remaining delay,
//   head first. Add, tick and dispatch each update all slots at once. A result
//   is built at acceptance and moved into the output register once that is
//   free; a dispatch that re-inserts a periodic task first makes a second pass
//   of the slot chain (remove the head, then insert). One request is in work
//   at a time, so a new one is taken only after the previous result has moved
//   into the output register, which holds a finished result while the next
//   request is accepted and executed; when the receiver stalls with a result
//   still waiting, the following result waits and no further request is
//   taken. Reset (i_rst_n low, synchronous) empties the list, restarts ids at
//   zero and drops any waiting result; slot contents need no clearing.
`default_nettype none

module sorted_delay_task_scheduler
    import sdts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // task_tag[7:0], start_delay[23:8], repeat_period[39:24]
    input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // run_tag[7:0], assigned_id[15:8], task_count[20:16]
    output logic [2:0]       m_axis_tuser   // status[1:0], run_valid[2]
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_REINS = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [ID_W-1:0]    r_next_id;
    logic               r_m_valid;

    // Result being built for the request in work.
    logic [STAT_W-1:0]  r_pend_status;
    logic               r_pend_run;
    logic [TAG_W-1:0]   r_pend_tag;
    logic [ID_W-1:0]    r_pend_id;
    logic [CW-1:0]      r_pend_cnt;

    // Head task saved for re-insertion.
    logic [TAG_W-1:0]   r_re_tag;
    logic [DELAY_W-1:0] r_re_per;

    logic [STAT_W-1:0]  r_m_status;
    logic               r_m_run;
    logic [TAG_W-1:0]   r_m_tag;
    logic [ID_W-1:0]    r_m_id;
    logic [CNT_W-1:0]   r_m_cnt;

    logic [1:0]         w_action;
    logic [TAG_W-1:0]   w_tag;
    logic [DELAY_W-1:0] w_delay;
    logic [DELAY_W-1:0] w_period;
    logic               w_accept;
    logic               w_full;
    logic               w_due;
    logic               w_out_free;
    logic [CW+CNT_W-1:0] w_cnt_ext;

    t_cell_cmd          w_cmd;
    t_entry             w_entry [MAX_TASKS];
    logic               w_stay  [MAX_TASKS];
    logic               w_occ   [MAX_TASKS];

    assign w_action = s_axis_tuser;
    assign w_tag    = s_axis_tdata[7:0];
    assign w_delay  = s_axis_tdata[23:8];
    assign w_period = s_axis_tdata[39:24];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(MAX_TASKS));
    assign w_due         = (r_count != '0) && (w_entry[0].delay == '0);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    always_comb begin
        w_cmd.op         = OP_HOLD;
        w_cmd.ins.delay  = w_delay;
        w_cmd.ins.period = w_period;
        w_cmd.ins.tag    = w_tag;
        w_cmd.ins.id     = r_next_id;
        if (r_state == S_REINS) begin
            w_cmd.op         = OP_INSERT;
            w_cmd.ins.delay  = r_re_per;
            w_cmd.ins.period = r_re_per;
            w_cmd.ins.tag    = r_re_tag;
        end else if (w_accept) begin
            unique case (w_action)
                ACT_ADD:      w_cmd.op = w_full ? OP_HOLD : OP_INSERT;
                ACT_TICK:     w_cmd.op = OP_TICK;
                ACT_DISPATCH: w_cmd.op = w_due ? OP_SHIFT_L : OP_HOLD;
                default:      w_cmd.op = OP_HOLD;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_stay;

            assign w_occ[gi] = (r_count > CW'(gi));

            if (gi == 0) begin : g_first
                // The head takes the new task unless it stays.
                assign w_left      = w_cmd.ins;
                assign w_left_stay = 1'b1;
            end else begin : g_mid
                assign w_left      = w_entry[gi-1];
                assign w_left_stay = w_stay[gi-1];
            end

            if (gi == MAX_TASKS - 1) begin : g_last
                assign w_right = w_entry[gi];
            end else begin : g_inner
                assign w_right = w_entry[gi+1];
            end

            sdts_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (w_occ[gi]),
                .i_left_stay (w_left_stay),
                .i_left      (w_left),
                .i_right     (w_right),
                .o_entry     (w_entry[gi]),
                .o_stay      (w_stay[gi])
            );
        end
    endgenerate

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DONE;
                        unique case (w_action)
                            ACT_ADD: begin
                                if (!w_full) begin
                                    r_count   <= r_count + CW'(1);
                                    r_next_id <= r_next_id + ID_W'(1);
                                end
                            end
                            ACT_DISPATCH: begin
                                if (w_due) begin
                                    r_count <= r_count - CW'(1);
                                    if (w_entry[0].period != '0) begin
                                        r_state <= S_REINS;
                                    end
                                end
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_REINS: begin
                    r_count   <= r_count + CW'(1);
                    r_next_id <= r_next_id + ID_W'(1);
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_pend_status <= ST_DONE;
            r_pend_run    <= 1'b0;
            r_pend_tag    <= '0;
            r_pend_id     <= '0;
            r_pend_cnt    <= r_count;
            r_re_tag      <= w_entry[0].tag;
            r_re_per      <= w_entry[0].period;
            unique case (w_action)
                ACT_ADD: begin
                    if (w_full) begin
                        r_pend_status <= ST_FULL;
                    end else begin
                        r_pend_id  <= r_next_id;
                        r_pend_cnt <= r_count + CW'(1);
                    end
                end
                ACT_DISPATCH: begin
                    if (!w_due) begin
                        r_pend_status <= ST_NOT_DUE;
                    end else begin
                        r_pend_run <= 1'b1;
                        r_pend_tag <= w_entry[0].tag;
                        r_pend_cnt <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_pend_status <= ST_DONE;
                end
            endcase
        end else if (r_state == S_REINS) begin
            r_pend_id  <= r_next_id;
            r_pend_cnt <= r_count + CW'(1);
        end

        if (r_state == S_DONE && w_out_free) begin
            r_m_status <= r_pend_status;
            r_m_run    <= r_pend_run;
            r_m_tag    <= r_pend_tag;
            r_m_id     <= r_pend_id;
            r_m_cnt    <= w_cnt_ext[CNT_W-1:0];
        end
    end

    assign w_cnt_ext = {{CNT_W{1'b0}}, r_pend_cnt};

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_cnt, r_m_id, r_m_tag};
    assign m_axis_tuser  = {r_m_run, r_m_status};

endmodule

`default_nettype wire
